FILE: hdl/ntlm_pkg.sv
// Shared types, constants and step helpers for the NTLM hash pipeline.
// No dependencies; imported by ntlm_md4_stage and ntlm_password_hash_top.
package ntlm_pkg;

  localparam int MAX_PW_CHARS = 27;
  localparam int NUM_STEPS    = 48;
  localparam int PW_BYTES     = 27;
  localparam int IN_DATA_W    = 224;
  localparam int OUT_DATA_W   = 128;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [31:0] K_R1 = 32'h5a827999;
  localparam logic [31:0] K_R2 = 32'h6ed9eba1;

  localparam logic [31:0] PAD_EVEN = 32'h00000080;
  localparam logic [31:0] PAD_ODD  = 32'h00800000;

  // chaining state, message block and too_long flag, carried stage to stage
  typedef struct packed {
    logic [31:0]       a;
    logic [31:0]       b;
    logic [31:0]       c;
    logic [31:0]       d;
    logic [15:0][31:0] blk;
    logic              too_long;
  } ntlm_pipe_t;

  // message word used by a given step
  function automatic logic [3:0] word_idx(input int step);
    logic [3:0] s;
    s = 4'(step % 16);
    case (step / 16)
      0:       word_idx = s;
      1:       word_idx = {s[1:0], s[3:2]};
      default: word_idx = {s[0], s[1], s[2], s[3]};
    endcase
  endfunction

  function automatic logic [4:0] rot_amt(input int step);
    logic [3:0] idx;
    idx = 4'((step / 16) * 4 + (step % 4));
    case (idx)
      4'd0:    rot_amt = 5'd3;
      4'd1:    rot_amt = 5'd7;
      4'd2:    rot_amt = 5'd11;
      4'd3:    rot_amt = 5'd19;
      4'd4:    rot_amt = 5'd3;
      4'd5:    rot_amt = 5'd5;
      4'd6:    rot_amt = 5'd9;
      4'd7:    rot_amt = 5'd13;
      4'd8:    rot_amt = 5'd3;
      4'd9:    rot_amt = 5'd9;
      4'd10:   rot_amt = 5'd11;
      default: rot_amt = 5'd15;
    endcase
  endfunction

  // one MD4 step; rotation amount is constant per stage
  function automatic ntlm_pipe_t md4_step(input ntlm_pipe_t p, input int step);
    ntlm_pipe_t  q;
    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] t;
    logic [4:0]  r;
    q = p;
    case (step / 16)
      0: begin
        f = p.d ^ (p.b & (p.c ^ p.d));
        k = 32'h0;
      end
      1: begin
        f = (p.b & (p.c | p.d)) | (p.c & p.d);
        k = K_R1;
      end
      default: begin
        f = p.b ^ p.c ^ p.d;
        k = K_R2;
      end
    endcase
    t = p.a + f + p.blk[word_idx(step)] + k;
    r = rot_amt(step);
    t = (t << r) | (t >> (6'd32 - {1'b0, r}));
    q.a = p.d;
    q.d = p.c;
    q.c = p.b;
    q.b = t;
    md4_step = q;
  endfunction

endpackage

FILE: hdl/ntlm_password_hash_top.sv
// NTLM password hash: block formatting, 48 pipelined MD4 steps, final add.
// Depends on ntlm_pkg and ntlm_md4_stage.
// Pipeline: formatter register, 48 MD4 step registers, output register.
// Throughput: one password per cycle unless the output stalls; every stage holds one item
// and empty stages fill while the output is stalled, so nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all stage valid bits; data regs keep junk.
module ntlm_password_hash_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata, low bit up: pw_bytes_0_7[63:0], pw_bytes_8_15[127:64],
  // pw_bytes_16_23[191:128], pw_bytes_24_26[215:192], pw_length[220:216], zero pad
  input  logic [ntlm_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // out_tdata, low bit up: digest_low[63:0], digest_high[127:64]
  output logic [ntlm_pkg::OUT_DATA_W-1:0]    out_tdata,
  // out_tuser: too_long[0]
  output logic                               out_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready
);
  import ntlm_pkg::*;

  // vld[i]/dat[i]: register after stage i (0 = formatter, 1..48 = MD4 steps)
  // rdy[i]: register i may load this cycle; rdy[NUM_STEPS+1] is the output reg
  logic       vld [0:NUM_STEPS];
  ntlm_pipe_t dat [0:NUM_STEPS];
  logic       rdy [0:NUM_STEPS+1];

  // ---------------- block formatting ----------------
  logic [7:0]  pw_byte [0:PW_BYTES];
  logic [4:0]  pw_len;
  logic [3:0]  len_half;
  ntlm_pipe_t  fmt_nxt;

  assign pw_len   = in_tdata[220:216];
  assign len_half = pw_len[4:1];

  always_comb begin
    for (int i = 0; i < PW_BYTES; i++) begin
      pw_byte[i] = in_tdata[8*i +: 8];
    end
    pw_byte[PW_BYTES] = 8'h00;   // only reached for lengths that are flagged anyway

    fmt_nxt.a = IV_A;
    fmt_nxt.b = IV_B;
    fmt_nxt.c = IV_C;
    fmt_nxt.d = IV_D;
    fmt_nxt.blk = '0;
    for (int j = 0; j < 14; j++) begin
      if (4'(j) < len_half) begin
        fmt_nxt.blk[j] = {8'h00, pw_byte[2*j+1], 8'h00, pw_byte[2*j]};
      end else if (4'(j) == len_half) begin
        // marker follows the last code unit; odd length leaves one byte in this word
        fmt_nxt.blk[j] = pw_len[0] ? (PAD_ODD | {24'h0, pw_byte[2*j]}) : PAD_EVEN;
      end
    end
    fmt_nxt.blk[14] = {23'h0, pw_len, 4'h0};   // bit length = 16 * chars
    fmt_nxt.too_long = (pw_len > 5'(MAX_PW_CHARS));
  end

  assign rdy[0]    = !vld[0] || rdy[1];
  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld[0] <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_tvalid) begin
      dat[0] <= fmt_nxt;
    end
  end

  // ---------------- MD4 step pipeline ----------------
  for (genvar s = 0; s < NUM_STEPS; s++) begin : g_step
    ntlm_md4_stage #(
      .STEP (s)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[s]),
      .up_data  (dat[s]),
      .up_ready (rdy[s+1]),
      .dn_valid (vld[s+1]),
      .dn_data  (dat[s+1]),
      .dn_ready (rdy[s+2])
    );
  end

  // ---------------- final add and output register ----------------
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_flag_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;
  ntlm_pipe_t            fin;

  assign fin = dat[NUM_STEPS];

  always_comb begin
    if (fin.too_long) begin
      out_data_nxt = '0;
    end else begin
      out_data_nxt = {IV_D + fin.d, IV_C + fin.c, IV_B + fin.b, IV_A + fin.a};
    end
  end

  assign rdy[NUM_STEPS+1] = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy[NUM_STEPS+1]) begin
      out_valid_r <= vld[NUM_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NUM_STEPS+1] && vld[NUM_STEPS]) begin
      out_data_r <= out_data_nxt;
      out_flag_r <= fin.too_long;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_flag_r;

  // ---------------- assertions ----------------
  // flagged transactions carry a zero digest
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("too_long result with nonzero digest");

  // input backpressure only comes from a full pipe behind a stalled output
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready && vld[0] && vld[NUM_STEPS])
    else $error("input stalled while pipeline has room");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("output valid or input stalled after reset");

endmodule

FILE: hdl/ntlm_md4_stage.sv
// One registered MD4 step of the hash pipeline, with bubble-collapsing flow control.
// Depends on ntlm_pkg.
module ntlm_md4_stage #(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  input  ntlm_pkg::ntlm_pipe_t up_data,
  output logic                up_ready,
  output logic                dn_valid,
  output ntlm_pkg::ntlm_pipe_t dn_data,
  input  logic                dn_ready
);
  import ntlm_pkg::*;

  logic       valid_r;
  ntlm_pipe_t data_r;
  ntlm_pipe_t data_nxt;

  assign up_ready = !valid_r || dn_ready;
  assign data_nxt = md4_step(up_data, STEP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule
